// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the top level of the majority filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/lmf_pkg.sv -----
// Package with the types, constants and register codes of the majority filter.
package lmf_pkg;

    localparam int unsigned MAX_WIDTH  = 1024;
    localparam int unsigned MAX_HEIGHT = 1024;
    localparam int unsigned LABEL_BITS = 8;

    localparam int unsigned DIM_BITS   = 11;
    localparam int unsigned COL_BITS   = $clog2(MAX_WIDTH);
    localparam int unsigned ROW_BITS   = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned NEED_BITS  = 4;
    localparam int unsigned CFG_BITS   = DIM_BITS;

    localparam int unsigned Q_DEPTH    = 4;
    localparam int unsigned Q_PTR_BITS = $clog2(Q_DEPTH);
    localparam int unsigned Q_LVL_BITS = $clog2(Q_DEPTH + 1);

    localparam logic [DIM_BITS-1:0]  FRAME_WIDTH_RST  = DIM_BITS'(1024);
    localparam logic [DIM_BITS-1:0]  FRAME_HEIGHT_RST = DIM_BITS'(1024);
    localparam logic [NEED_BITS-1:0] MIN_COUNT_RST    = NEED_BITS'(6);
    localparam logic [NEED_BITS-1:0] MIN_NEED         = NEED_BITS'(5);

    // Positions of the eight neighbours inside the 3x3 window (centre is 4).
    localparam int unsigned NB_IDX [0:7] = '{0, 1, 2, 3, 5, 6, 7, 8};

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_MIN_COUNT    = 2'd2
    } reg_index_t;

    typedef enum logic {
        FUNC_PIXEL = 1'b0,
        FUNC_DRAIN = 1'b1
    } func_t;

    typedef logic [LABEL_BITS-1:0] label_t;

    // One classified item on its way from the front end to the back end.
    typedef struct packed {
        logic   shift;
        logic   emit;
        logic   interior;
        logic   last;
        label_t upper;
        label_t middle;
        label_t label;
    } lmf_entry_t;

    typedef struct packed {
        logic in_done;
        logic out_done;
    } front_stat_t;

endpackage

// ----- rtl/core/lmf_ram.sv -----
// Generic simple dual-port RAM with a registered read port.
module lmf_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/lmf_front.sv -----
// Front end: accepts items, tracks frame position and feeds the line buffers.
module lmf_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  logic                             func,
    input  logic [lmf_pkg::LABEL_BITS-1:0]   pixel_label,
    output logic                             full,
    input  logic                             restart,
    input  logic [lmf_pkg::DIM_BITS-1:0]     w_eff,
    input  logic [lmf_pkg::DIM_BITS-1:0]     h_eff,
    input  logic [lmf_pkg::Q_LVL_BITS-1:0]   q_level,
    output logic                             q_push,
    output lmf_pkg::lmf_entry_t              q_entry,
    output lmf_pkg::front_stat_t             stat
);

    logic [lmf_pkg::COL_BITS-1:0] in_col_reg,  in_col_next;
    logic [lmf_pkg::ROW_BITS-1:0] in_row_reg,  in_row_next;
    logic [lmf_pkg::COL_BITS-1:0] out_col_reg, out_col_next;
    logic [lmf_pkg::ROW_BITS-1:0] out_row_reg, out_row_next;

    logic                         f1_valid_reg, f1_valid_next;
    logic                         f1_shift_reg, f1_emit_reg, f1_interior_reg, f1_last_reg;
    logic [lmf_pkg::COL_BITS-1:0] f1_addr_reg;
    lmf_pkg::label_t              f1_label_reg;

    logic                         byp_reg, byp_next;
    lmf_pkg::label_t              byp_upper_reg, byp_middle_reg;

    logic                         accept, is_pixel, in_done, out_done, new_frame, emit;
    logic                         interior, last;
    logic [lmf_pkg::COL_BITS-1:0] b_in_col, b_out_col;
    logic [lmf_pkg::ROW_BITS-1:0] b_in_row, b_out_row;
    logic [lmf_pkg::DIM_BITS-1:0] w_last, h_last;

    lmf_pkg::label_t upper_rd, middle_rd, up_val, mid_val;

    assign full     = (q_level + lmf_pkg::Q_LVL_BITS'(f1_valid_reg))
                      >= lmf_pkg::Q_LVL_BITS'(lmf_pkg::Q_DEPTH);
    assign accept   = push && !full;
    assign is_pixel = (func == lmf_pkg::FUNC_PIXEL);
    assign w_last   = w_eff - lmf_pkg::DIM_BITS'(1);
    assign h_last   = h_eff - lmf_pkg::DIM_BITS'(1);

    always_comb
    begin
        in_done   = (lmf_pkg::DIM_BITS'(in_row_reg) == h_eff);
        out_done  = (lmf_pkg::DIM_BITS'(out_row_reg) == h_eff);
        // A pixel arriving after a complete frame opens the next frame.
        new_frame = is_pixel && in_done;
        b_in_col  = new_frame ? '0 : in_col_reg;
        b_in_row  = new_frame ? '0 : in_row_reg;
        b_out_col = new_frame ? '0 : out_col_reg;
        b_out_row = new_frame ? '0 : out_row_reg;

        // A pixel releases the result that lies one row and one pixel behind it.
        if (is_pixel)
        begin
            emit = (b_in_row >= lmf_pkg::ROW_BITS'(2))
                || ((b_in_row == lmf_pkg::ROW_BITS'(1)) && (b_in_col != '0));
        end
        else
        begin
            emit = in_done && !out_done;
        end

        interior = (b_out_row != '0) && (b_out_col != '0)
                && ((lmf_pkg::DIM_BITS'(b_out_row) + lmf_pkg::DIM_BITS'(1)) < h_eff)
                && ((lmf_pkg::DIM_BITS'(b_out_col) + lmf_pkg::DIM_BITS'(1)) < w_eff);
        last     = (lmf_pkg::DIM_BITS'(b_out_row) == h_last)
                && (lmf_pkg::DIM_BITS'(b_out_col) == w_last);

        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;

        if (restart)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (accept)
        begin
            if (is_pixel)
            begin
                if (lmf_pkg::DIM_BITS'(b_in_col) == w_last)
                begin
                    in_col_next = '0;
                    in_row_next = b_in_row + lmf_pkg::ROW_BITS'(1);
                end
                else
                begin
                    in_col_next = b_in_col + lmf_pkg::COL_BITS'(1);
                    in_row_next = b_in_row;
                end
            end
            out_col_next = b_out_col;
            out_row_next = b_out_row;
            if (emit)
            begin
                if (lmf_pkg::DIM_BITS'(b_out_col) == w_last)
                begin
                    out_col_next = '0;
                    out_row_next = b_out_row + lmf_pkg::ROW_BITS'(1);
                end
                else
                begin
                    out_col_next = b_out_col + lmf_pkg::COL_BITS'(1);
                end
            end
        end

        f1_valid_next = accept && (is_pixel || emit);
        // The RAM returns stale data when the entry is rewritten in the same cycle.
        byp_next = f1_valid_reg && f1_shift_reg && accept && is_pixel
                && (f1_addr_reg == b_in_col);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            f1_valid_reg <= 1'b0;
            byp_reg      <= 1'b0;
        end
        else
        begin
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            f1_valid_reg <= f1_valid_next;
            byp_reg      <= byp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f1_shift_reg    <= is_pixel;
            f1_emit_reg     <= emit;
            f1_interior_reg <= interior;
            f1_last_reg     <= last;
            f1_addr_reg     <= b_in_col;
            f1_label_reg    <= pixel_label;
        end
        byp_upper_reg  <= mid_val;
        byp_middle_reg <= f1_label_reg;
    end

    assign up_val  = byp_reg ? byp_upper_reg  : upper_rd;
    assign mid_val = byp_reg ? byp_middle_reg : middle_rd;

    lmf_ram #(
        .WIDTH (lmf_pkg::LABEL_BITS),
        .DEPTH (lmf_pkg::MAX_WIDTH)
    ) u_upper (
        .clk     (clk),
        .wr_en   (f1_valid_reg && f1_shift_reg),
        .wr_addr (f1_addr_reg),
        .wr_data (mid_val),
        .rd_addr (b_in_col),
        .rd_data (upper_rd)
    );

    lmf_ram #(
        .WIDTH (lmf_pkg::LABEL_BITS),
        .DEPTH (lmf_pkg::MAX_WIDTH)
    ) u_middle (
        .clk     (clk),
        .wr_en   (f1_valid_reg && f1_shift_reg),
        .wr_addr (f1_addr_reg),
        .wr_data (f1_label_reg),
        .rd_addr (b_in_col),
        .rd_data (middle_rd)
    );

    always_comb
    begin
        q_push           = f1_valid_reg;
        q_entry.shift    = f1_shift_reg;
        q_entry.emit     = f1_emit_reg;
        q_entry.interior = f1_interior_reg;
        q_entry.last     = f1_last_reg;
        q_entry.upper    = up_val;
        q_entry.middle   = mid_val;
        q_entry.label    = f1_label_reg;
        stat.in_done     = in_done;
        stat.out_done    = out_done;
    end

endmodule

// ----- rtl/core/lmf_queue.sv -----
// Short queue of classified items between the front end and the back end.
module lmf_queue (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  lmf_pkg::lmf_entry_t            push_entry,
    input  logic                           pop,
    output lmf_pkg::lmf_entry_t            head,
    output logic                           empty,
    output logic [lmf_pkg::Q_LVL_BITS-1:0] level
);

    lmf_pkg::lmf_entry_t            slot_reg [0:lmf_pkg::Q_DEPTH-1];
    logic [lmf_pkg::Q_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [lmf_pkg::Q_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [lmf_pkg::Q_LVL_BITS-1:0] level_reg, level_next;
    logic                           do_pop;

    assign empty  = (level_reg == '0);
    assign do_pop = pop && !empty;
    assign head   = slot_reg[rd_ptr_reg];
    assign level  = level_reg;

    always_comb
    begin
        wr_ptr_next = push   ? wr_ptr_reg + lmf_pkg::Q_PTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + lmf_pkg::Q_PTR_BITS'(1) : rd_ptr_reg;
        level_next  = level_reg + lmf_pkg::Q_LVL_BITS'(push)
                    - lmf_pkg::Q_LVL_BITS'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ----- rtl/core/lmf_back.sv -----
// Back end: 3x3 window, two-stage majority vote and the result queue.
module lmf_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_empty,
    input  lmf_pkg::lmf_entry_t             q_head,
    output logic                            q_pop,
    input  logic [lmf_pkg::NEED_BITS-1:0]   need,
    input  logic                            pop,
    output logic                            empty,
    output logic [lmf_pkg::LABEL_BITS-1:0]  filtered_label,
    output logic                            frame_last
);

    lmf_pkg::label_t [8:0]          win_reg, win_next;

    logic                           a_valid_reg, a_interior_reg, a_last_reg;
    logic                           b_valid_reg, b_interior_reg, b_last_reg;
    logic [7:0][7:0]                b_eq_reg, eq_next;
    lmf_pkg::label_t [7:0]          b_nb_reg, nb_next;

    lmf_pkg::label_t                of_label_reg [0:lmf_pkg::Q_DEPTH-1];
    logic                           of_last_reg  [0:lmf_pkg::Q_DEPTH-1];
    logic [lmf_pkg::Q_PTR_BITS-1:0] of_wr_reg, of_rd_reg;
    logic [lmf_pkg::Q_LVL_BITS-1:0] of_level_reg;
    logic [lmf_pkg::Q_LVL_BITS-1:0] committed;
    logic                           of_pop;

    logic [3:0]                     cnt [0:7];
    logic                           found;
    lmf_pkg::label_t                sel, result;

    // Items are taken only when the result queue has room for every vote in flight.
    assign committed = of_level_reg + lmf_pkg::Q_LVL_BITS'(a_valid_reg)
                     + lmf_pkg::Q_LVL_BITS'(b_valid_reg);
    assign q_pop     = !q_empty && (committed < lmf_pkg::Q_LVL_BITS'(lmf_pkg::Q_DEPTH));

    always_comb
    begin
        win_next = win_reg;
        if (q_pop && q_head.shift)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_next[r*3+0] = win_reg[r*3+1];
                win_next[r*3+1] = win_reg[r*3+2];
            end
            win_next[2] = q_head.upper;
            win_next[5] = q_head.middle;
            win_next[8] = q_head.label;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            nb_next[i] = win_reg[lmf_pkg::NB_IDX[i]];
            for (int j = 0; j < 8; j++)
            begin
                eq_next[i][j] = (win_reg[lmf_pkg::NB_IDX[i]] == win_reg[lmf_pkg::NB_IDX[j]]);
            end
        end
    end

    always_comb
    begin
        found = 1'b0;
        sel   = '0;
        for (int i = 0; i < 8; i++)
        begin
            cnt[i] = 4'($countones(b_eq_reg[i]));
            if (!found && (cnt[i] >= need))
            begin
                found = 1'b1;
                sel   = b_nb_reg[i];
            end
        end
        result = (b_interior_reg && found) ? sel : '0;
    end

    assign empty          = (of_level_reg == '0);
    assign of_pop         = pop && !empty;
    assign filtered_label = of_label_reg[of_rd_reg];
    assign frame_last     = of_last_reg[of_rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg      <= '0;
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
            of_wr_reg    <= '0;
            of_rd_reg    <= '0;
            of_level_reg <= '0;
        end
        else
        begin
            win_reg      <= win_next;
            a_valid_reg  <= q_pop && q_head.emit;
            b_valid_reg  <= a_valid_reg;
            if (b_valid_reg)
            begin
                of_wr_reg <= of_wr_reg + lmf_pkg::Q_PTR_BITS'(1);
            end
            if (of_pop)
            begin
                of_rd_reg <= of_rd_reg + lmf_pkg::Q_PTR_BITS'(1);
            end
            of_level_reg <= of_level_reg + lmf_pkg::Q_LVL_BITS'(b_valid_reg)
                          - lmf_pkg::Q_LVL_BITS'(of_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            a_interior_reg <= q_head.interior;
            a_last_reg     <= q_head.last;
        end
        b_interior_reg <= a_interior_reg;
        b_last_reg     <= a_last_reg;
        b_eq_reg       <= eq_next;
        b_nb_reg       <= nb_next;
        if (b_valid_reg)
        begin
            of_label_reg[of_wr_reg] <= result;
            of_last_reg[of_wr_reg]  <= b_last_reg;
        end
    end

endmodule

// ----- rtl/core/label_majority_filter_3x3_top.sv -----
// Top level of the 3x3 label majority filter.
//
// The block runs one majority filter pass over a raster stream of labels.
// Input items enter with push while full is low; func selects a pixel label
// or a drain item. Results leave like a queue: while empty is low the oldest
// result stands on filtered_label and frame_last, and pop takes it.
// Each pixel releases the result of the pixel one row and one position
// behind it, so the results of a frame lag its input by frame_width + 1
// pixels; after the last pixel of a frame, drain items release the remaining
// results one per item. The block takes one item per clock while full is
// low. A released result passes the line-buffer read register, the item
// queue and the two window vote stages before it enters the result queue.
// When the receiver stops popping, the four-entry result queue fills, the
// back end stops taking items, the item queue fills and full rises; nothing
// is lost. Reset empties both queues and restarts the frame with a width and
// height of 1024 and a threshold of 6. The line buffers need no clearing
// after reset, so items are taken from the first cycle.
// Writing the frame width or height restarts the frame; the threshold takes
// effect at once.
`include "assert_macros.svh"

module label_majority_filter_3x3_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [1:0]                     cfg_index,
    input  logic [lmf_pkg::CFG_BITS-1:0]   cfg_data,
    input  logic                           push,
    output logic                           full,
    input  logic                           func,
    input  logic [lmf_pkg::LABEL_BITS-1:0] pixel_label,
    output logic                           empty,
    input  logic                           pop,
    output logic [lmf_pkg::LABEL_BITS-1:0] filtered_label,
    output logic                           frame_last
);

    logic [lmf_pkg::DIM_BITS-1:0]   width_reg, height_reg;
    logic [lmf_pkg::NEED_BITS-1:0]  min_count_reg;
    logic [lmf_pkg::DIM_BITS-1:0]   w_eff, h_eff;
    logic [lmf_pkg::NEED_BITS-1:0]  need;
    logic                           restart;

    logic                           q_push, q_pop, q_empty;
    lmf_pkg::lmf_entry_t            q_entry, q_head;
    logic [lmf_pkg::Q_LVL_BITS-1:0] q_level;
    lmf_pkg::front_stat_t           stat;

    // Configuration registers; a write of either frame dimension restarts the frame.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= lmf_pkg::FRAME_WIDTH_RST;
            height_reg    <= lmf_pkg::FRAME_HEIGHT_RST;
            min_count_reg <= lmf_pkg::MIN_COUNT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                lmf_pkg::REG_FRAME_WIDTH:  width_reg     <= cfg_data;
                lmf_pkg::REG_FRAME_HEIGHT: height_reg    <= cfg_data;
                lmf_pkg::REG_MIN_COUNT:    min_count_reg <= cfg_data[lmf_pkg::NEED_BITS-1:0];
                default:                   ;
            endcase
        end
    end

    assign restart = cfg_write && ((cfg_index == lmf_pkg::REG_FRAME_WIDTH)
                                || (cfg_index == lmf_pkg::REG_FRAME_HEIGHT));

    // Dimensions out of range are clamped; a threshold below five counts as five.
    always_comb
    begin
        if (width_reg == '0)
            w_eff = lmf_pkg::DIM_BITS'(1);
        else if (width_reg > lmf_pkg::DIM_BITS'(lmf_pkg::MAX_WIDTH))
            w_eff = lmf_pkg::DIM_BITS'(lmf_pkg::MAX_WIDTH);
        else
            w_eff = width_reg;

        if (height_reg == '0)
            h_eff = lmf_pkg::DIM_BITS'(1);
        else if (height_reg > lmf_pkg::DIM_BITS'(lmf_pkg::MAX_HEIGHT))
            h_eff = lmf_pkg::DIM_BITS'(lmf_pkg::MAX_HEIGHT);
        else
            h_eff = height_reg;

        need = (min_count_reg < lmf_pkg::MIN_NEED) ? lmf_pkg::MIN_NEED : min_count_reg;
    end

    lmf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .func        (func),
        .pixel_label (pixel_label),
        .full        (full),
        .restart     (restart),
        .w_eff       (w_eff),
        .h_eff       (h_eff),
        .q_level     (q_level),
        .q_push      (q_push),
        .q_entry     (q_entry),
        .stat        (stat)
    );

    lmf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .empty      (q_empty),
        .level      (q_level)
    );

    lmf_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .need           (need),
        .pop            (pop),
        .empty          (empty),
        .filtered_label (filtered_label),
        .frame_last     (frame_last)
    );

    // The item queue never holds more items than it has slots.
    `ASSERT_ALWAYS(a_queue_bound, q_level <= lmf_pkg::Q_LVL_BITS'(lmf_pkg::Q_DEPTH), "item queue overflow")

    // All results of a frame can only be out once all of its pixels are in.
    `ASSERT_IMPLIES(a_out_after_in, stat.out_done, stat.in_done, "results ran ahead of input")

    // A geometry write leaves an empty, freshly started frame.
    `ASSERT_NEXT(a_geom_restart, restart, !stat.in_done && !stat.out_done, "frame not restarted")

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the 3x3 label majority filter, with its own prediction of the block.
module tb_top;
    import lmf_pkg::*;

    // The longest correct stretch without any accepted item or result is a
    // settle pause plus three register writes, a sender gap and a receiver
    // stall. The limit leaves a wide margin above it.
    localparam int unsigned IDLE_LIMIT    = 2000;
    // Pause before a register write so that items without a result have left
    // the block's pipeline.
    localparam int unsigned SETTLE_CYCLES = 12;
    localparam int unsigned END_CYCLES    = 20;
    localparam int unsigned RANDOM_ITEMS  = 600;
    // The final stretch of the random part runs without random sender gaps or receiver stalls.
    localparam int unsigned QUIET_ITEMS   = 250;
    localparam int unsigned MAX_REPORTS   = 100;

    typedef struct {
        label_t label;
        logic   last;
    } filt_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [1:0]           cfg_index;
    logic [CFG_BITS-1:0]  cfg_data;
    logic                 push;
    logic                 full;
    logic                 func;
    label_t               pixel_label;
    logic                 empty;
    logic                 pop;
    label_t               filtered_label;
    logic                 frame_last;

    // Shadow of the block: registers, line stores, window and frame counts.
    logic [DIM_BITS-1:0]  width_reg;
    logic [DIM_BITS-1:0]  height_reg;
    logic [NEED_BITS-1:0] need_reg;
    label_t               row_two_up [MAX_WIDTH];
    label_t               row_one_up [MAX_WIDTH];
    label_t               window [9];
    int unsigned          pixels_in;
    int unsigned          results_out;

    // Filter results that the block still owes, oldest first.
    filt_result_t         owed_results [$];
    filt_result_t         want;

    int unsigned          error_count;
    int unsigned          items_done;
    int unsigned          idle_cycles;
    int unsigned          stall_left;
    bit                   quiet;
    bit                   tx_idle_en;
    bit                   rx_idle_en;

    label_majority_filter_3x3_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .push           (push),
        .full           (full),
        .func           (func),
        .pixel_label    (pixel_label),
        .empty          (empty),
        .pop            (pop),
        .filtered_label (filtered_label),
        .frame_last     (frame_last)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report_mismatch(string what);
        error_count++;
        if (error_count <= MAX_REPORTS)
        begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    // A width or height of zero acts as one; values above the maximum act as the maximum.
    function automatic int unsigned eff_dim(logic [DIM_BITS-1:0] v, int unsigned hi);
        if (v == 0)
        begin
            return 1;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    // Majority vote over the eight neighbours; the centre does not take part.
    // A threshold below five acts as five, so no two labels can both win.
    function automatic label_t window_vote();
        int unsigned need;
        int unsigned hits;
        need = (need_reg < MIN_NEED) ? MIN_NEED : need_reg;
        for (int i = 0; i < 9; i++)
        begin
            if (i == 4)
            begin
                continue;
            end
            hits = 0;
            for (int j = 0; j < 9; j++)
            begin
                if (j != 4 && window[j] == window[i])
                begin
                    hits++;
                end
            end
            if (hits >= need)
            begin
                return window[i];
            end
        end
        return '0;
    endfunction

    function automatic void owe_result(int unsigned pos, int unsigned w, int unsigned h);
        filt_result_t r;
        int unsigned  row_i;
        int unsigned  col_i;
        row_i   = pos / w;
        col_i   = pos % w;
        r.label = '0;
        if (row_i >= 1 && row_i + 1 < h && col_i >= 1 && col_i + 1 < w)
        begin
            r.label = window_vote();
        end
        r.last = (pos == w * h - 1);
        owed_results.push_back(r);
    endfunction

    // Advances the shadow by one accepted item; returns 1 when it releases a result.
    function automatic bit filter_step(func_t f, label_t lbl);
        int unsigned w;
        int unsigned h;
        int unsigned total;
        int unsigned col;
        w     = eff_dim(width_reg, MAX_WIDTH);
        h     = eff_dim(height_reg, MAX_HEIGHT);
        total = w * h;
        if (f == FUNC_DRAIN)
        begin
            // A drain only releases tail results of a fully received frame.
            if (pixels_in >= total && results_out < total)
            begin
                owe_result(results_out, w, h);
                results_out++;
                return 1;
            end
            return 0;
        end
        // A pixel after a complete frame opens a new one; the undrained tail is dropped.
        if (pixels_in >= total)
        begin
            pixels_in   = 0;
            results_out = 0;
        end
        col = pixels_in % w;
        for (int r = 0; r < 3; r++)
        begin
            window[r * 3]     = window[r * 3 + 1];
            window[r * 3 + 1] = window[r * 3 + 2];
        end
        window[2]       = row_two_up[col];
        window[5]       = row_one_up[col];
        window[8]       = lbl;
        row_two_up[col] = row_one_up[col];
        row_one_up[col] = lbl;
        pixels_in++;
        if (results_out + w + 2 <= pixels_in)
        begin
            owe_result(results_out, w, h);
            results_out++;
            return 1;
        end
        return 0;
    endfunction

    // Offers one item and holds it until the block takes it. Push stays high
    // afterwards so that back-to-back items need no second assignment.
    task automatic send_item(func_t f, label_t lbl);
        int unsigned gap;
        bit          released;
        if (!quiet && tx_idle_en && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 10);
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push        <= 1'b1;
        func        <= f;
        pixel_label <= lbl;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        released = filter_step(f, lbl);
        if (released || f == FUNC_PIXEL)
        begin
            items_done++;
        end
    endtask

    // Always lets one clock edge pass, so push is never driven twice at once.
    task automatic wait_results_flushed();
        push <= 1'b0;
        @(posedge clk);
        while (owed_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Brings the block to rest before a register write: all results taken and
    // items that release nothing given time to leave the pipeline.
    task automatic settle();
        wait_results_flushed();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [CFG_BITS-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH:
            begin
                width_reg   = value;
                pixels_in   = 0;
                results_out = 0;
            end
            REG_FRAME_HEIGHT:
            begin
                height_reg  = value;
                pixels_in   = 0;
                results_out = 0;
            end
            REG_MIN_COUNT:
            begin
                need_reg = value[NEED_BITS-1:0];
            end
            default:
            begin
            end
        endcase
        @(posedge clk);
    endtask

    // Default geometry is 1024 x 1024, so nothing can come out yet; the drain
    // arrives before the frame is complete and must release nothing.
    task automatic test_after_reset();
        send_item(FUNC_DRAIN, 8'hFF);
        send_item(FUNC_PIXEL, 8'h00);
        send_item(FUNC_PIXEL, 8'hFF);
        settle();
    endtask

    // Two 3 x 3 frames, each with a single interior pixel.
    task automatic test_small_frames();
        write_reg(REG_FRAME_WIDTH, CFG_BITS'(3));
        write_reg(REG_FRAME_HEIGHT, CFG_BITS'(3));
        // With the highest threshold nothing can win, even eight equal neighbours.
        write_reg(REG_MIN_COUNT, CFG_BITS'(15));
        for (int i = 0; i < 9; i++)
        begin
            send_item(FUNC_PIXEL, (i == 4) ? 8'h00 : 8'hFF);
        end
        // Only part of the tail is drained here.
        send_item(FUNC_DRAIN, 8'h00);
        send_item(FUNC_DRAIN, 8'hFF);
        settle();
        // A threshold of zero acts as five: five 0xFF neighbours against three
        // zeros must win. The first pixel drops the undrained tail above.
        write_reg(REG_MIN_COUNT, CFG_BITS'(0));
        for (int i = 0; i < 9; i++)
        begin
            send_item(FUNC_PIXEL, (i < 4 || i == 5) ? 8'hFF : 8'h00);
        end
        // Four drains release the border tail, the last one marks the frame
        // end; the fifth finds nothing pending.
        for (int i = 0; i < 5; i++)
        begin
            send_item(FUNC_DRAIN, label_t'($urandom));
        end
        settle();
    endtask

    // Geometry at and beyond its limits: zero acts as one, 2047 as 1024.
    task automatic test_geometry_extremes();
        write_reg(REG_FRAME_WIDTH, CFG_BITS'(0));
        write_reg(REG_FRAME_HEIGHT, CFG_BITS'(0));
        write_reg(REG_MIN_COUNT, CFG_BITS'(8));
        send_item(FUNC_PIXEL, 8'h81);
        send_item(FUNC_DRAIN, 8'h00);
        send_item(FUNC_DRAIN, 8'h00);
        send_item(FUNC_PIXEL, 8'h7E);
        send_item(FUNC_DRAIN, 8'h00);
        settle();
        // One row of the full width: every result comes from a drain.
        write_reg(REG_FRAME_WIDTH, {CFG_BITS{1'b1}});
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            send_item(FUNC_PIXEL, label_t'($urandom));
        end
        for (int i = 0; i < 3; i++)
        begin
            send_item(FUNC_DRAIN, label_t'($urandom));
        end
        settle();
    endtask

    // Phases of random settings. Most frames are complete frames drawn chiefly
    // from a two-label palette so that majorities actually occur; the rest is noise.
    task automatic test_random_frames();
        int unsigned w_sel;
        int unsigned h_sel;
        int unsigned thr_sel;
        int unsigned total;
        int unsigned remaining;
        int unsigned tail;
        int unsigned frames;
        int unsigned share;
        label_t      major;
        label_t      minor;
        items_done = 0;
        while (items_done < RANDOM_ITEMS)
        begin
            settle();
            case ($urandom_range(0, 9))
                0: w_sel = $urandom_range(0, 2);
                1, 2, 3, 4, 5, 6: w_sel = $urandom_range(3, 8);
                default: w_sel = $urandom_range(9, 40);
            endcase
            h_sel   = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
            thr_sel = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : $urandom_range(5, 8);
            if ($urandom_range(0, 3) != 0)
            begin
                write_reg(REG_MIN_COUNT, CFG_BITS'(thr_sel));
            end
            if ($urandom_range(0, 3) != 0)
            begin
                write_reg(REG_FRAME_WIDTH, CFG_BITS'(w_sel));
            end
            if ($urandom_range(0, 3) != 0)
            begin
                write_reg(REG_FRAME_HEIGHT, CFG_BITS'(h_sel));
            end
            tx_idle_en = ($urandom_range(0, 2) != 0);
            rx_idle_en = ($urandom_range(0, 2) != 0);
            frames     = $urandom_range(1, 4);
            for (int fr = 0; fr < frames; fr++)
            begin
                quiet = (items_done + QUIET_ITEMS >= RANDOM_ITEMS);
                total = eff_dim(width_reg, MAX_WIDTH) * eff_dim(height_reg, MAX_HEIGHT);
                if ($urandom_range(0, 9) == 0)
                begin
                    // Noise: random pixels and drains, early drains included.
                    remaining = $urandom_range(1, 2 * total + 4);
                    for (int i = 0; i < remaining; i++)
                    begin
                        send_item(func_t'($urandom_range(0, 1)), label_t'($urandom));
                    end
                    continue;
                end
                major     = label_t'($urandom);
                minor     = label_t'($urandom);
                share     = $urandom_range(60, 95);
                remaining = (pixels_in >= total) ? total : total - pixels_in;
                for (int i = 0; i < remaining; i++)
                begin
                    if ($urandom_range(0, 14) == 0)
                    begin
                        send_item(FUNC_DRAIN, label_t'($urandom));
                    end
                    if ($urandom_range(0, 49) == 0)
                    begin
                        wait_results_flushed();
                    end
                    if ($urandom_range(1, 100) <= share)
                    begin
                        send_item(FUNC_PIXEL, major);
                    end
                    else if ($urandom_range(0, 1) == 0)
                    begin
                        send_item(FUNC_PIXEL, minor);
                    end
                    else
                    begin
                        send_item(FUNC_PIXEL, label_t'($urandom));
                    end
                end
                // Drain the tail exactly, partly, or past its end.
                tail = total - results_out;
                case ($urandom_range(0, 5))
                    0: tail = $urandom_range(0, tail);
                    1: tail = tail + $urandom_range(1, 3);
                    default: ;
                endcase
                for (int i = 0; i < tail; i++)
                begin
                    send_item(FUNC_DRAIN, label_t'($urandom));
                end
            end
        end
    endtask

    // Result check and receiver stalls. Outputs are read at the clock edge,
    // before the block's own updates of that edge take effect.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (owed_results.size() == 0)
                begin
                    report_mismatch($sformatf("result %0h arrived with none owed",
                                              filtered_label));
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (filtered_label !== want.label)
                    begin
                        report_mismatch($sformatf("filtered_label %0h, expected %0h",
                                                  filtered_label, want.label));
                    end
                    if (frame_last !== want.last)
                    begin
                        report_mismatch($sformatf("frame_last %0b, expected %0b",
                                                  frame_last, want.last));
                    end
                end
            end
            if (stall_left != 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else if (!quiet && rx_idle_en && $urandom_range(0, 7) == 0)
            begin
                // Starts a receiver stall that includes this cycle; stall_left counts the rest.
                stall_left = $urandom_range(0, 9);
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    // Watchdog: ends the run when neither side has moved for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("** label_majority_filter_3x3_top: FAILED **");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        rst_n       <= 1'b0;
        cfg_write   <= 1'b0;
        cfg_index   <= REG_FRAME_WIDTH;
        cfg_data    <= '0;
        push        <= 1'b0;
        func        <= FUNC_PIXEL;
        pixel_label <= '0;
        pop         <= 1'b0;
        // Shadow state as the block leaves reset.
        width_reg   = FRAME_WIDTH_RST;
        height_reg  = FRAME_HEIGHT_RST;
        need_reg    = MIN_COUNT_RST;
        pixels_in   = 0;
        results_out = 0;
        for (int i = 0; i < 9; i++)
        begin
            window[i] = '0;
        end
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            row_two_up[i] = '0;
            row_one_up[i] = '0;
        end
        error_count = 0;
        items_done  = 0;
        idle_cycles = 0;
        stall_left  = 0;
        quiet       = 1'b0;
        tx_idle_en  = 1'b1;
        rx_idle_en  = 1'b1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_after_reset();
        test_small_frames();
        test_geometry_extremes();
        test_random_frames();

        quiet = 1'b1;
        wait_results_flushed();
        repeat (END_CYCLES) @(posedge clk);
        if (owed_results.size() != 0)
        begin
            report_mismatch($sformatf("%0d results never arrived", owed_results.size()));
        end
        if (error_count == 0)
        begin
            $display("** label_majority_filter_3x3_top: PASSED **");
        end
        else
        begin
            $display("** label_majority_filter_3x3_top: FAILED **");
        end
        $finish;
    end

endmodule
